// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk_i and switched off while rst_ni is low.
`define MMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion clocked on clk_i that also holds during reset.
`define MMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/mmc_pkg.sv =====
// Package with the command codes, field widths and types of the misclassification cost block.
`default_nettype none

package mmc_pkg;

  localparam int CMD_W      = 2;
  localparam int CLS_FLD_W  = 3;
  localparam int LOSS_W     = 16;
  localparam int COST_W     = 35;
  localparam int NCLS_W     = 4;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  localparam logic              REG_NUM_CLASSES = 1'b0;
  localparam logic [NCLS_W-1:0] NCLS_RESET      = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/min_misclassification_cost.sv =====
// Top level of the minimum expected misclassification cost block.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   command, sample_class, loss_row,
//                                                 loss_col, loss_value
//   out      output     out_valid_o / out_ready_i min_cost
//   cfg      input      APB psel / penable        num_classes at byte address 0
//
// Load and sample items may follow one another in every cycle while no finish is in progress.
// A finish item holds the input while the loss table is walked through its single read port,
// one entry a cycle over the n*n entries of n active classes, through a multiply-accumulate.
// No item is accepted from a finish until its result sits in the output register.
// The output register holds one result, so a finish waits there while it is occupied.
// Reset clears the class counts through per-class valid bits; the loss table is not cleared.
`default_nettype none

module min_misclassification_cost
  import mmc_pkg::*;
#(
  parameter int MAX_CLASSES = 8,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CMD_W-1:0]     command_i,
  input  wire logic [CLS_FLD_W-1:0] sample_class_i,
  input  wire logic [CLS_FLD_W-1:0] loss_row_i,
  input  wire logic [CLS_FLD_W-1:0] loss_col_i,
  input  wire logic [LOSS_W-1:0]    loss_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [COST_W-1:0]         min_cost_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [APB_AW-1:0]    paddr,
  input  wire logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int NC_W   = $clog2(MAX_CLASSES + 1);
  localparam int LA_W   = $clog2(MAX_CLASSES * MAX_CLASSES);
  localparam int PROD_W = COUNT_BITS + LOSS_W;
  localparam int SUM_W  = PROD_W + CLS_W;

  // Configuration register.
  logic [NCLS_W-1:0] ncls_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_CLASSES);
  assign prdata = (paddr[2] == REG_NUM_CLASSES) ? APB_DW'(ncls_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncls_q <= NCLS_RESET;
    end else if (cfg_wr) begin
      ncls_q <= pwdata[NCLS_W-1:0];
    end
  end

  logic [NC_W-1:0]  n_eff;
  logic [CLS_W-1:0] last_idx;

  always_comb begin
    if (ncls_q == '0) begin
      n_eff = NC_W'(1);
    end else if (8'(ncls_q) > 8'(MAX_CLASSES)) begin
      n_eff = NC_W'(MAX_CLASSES);
    end else begin
      n_eff = NC_W'(ncls_q);
    end
  end

  assign last_idx = CLS_W'(n_eff - NC_W'(1));

  // Input decode.
  state_e state_q, state_d;
  logic   in_acc;
  logic   acc_load, acc_sample, acc_finish;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign acc_load   = in_acc && (command_i == CMD_LOAD) &&
                      (8'(loss_row_i) < 8'(MAX_CLASSES)) &&
                      (8'(loss_col_i) < 8'(MAX_CLASSES));
  assign acc_sample = in_acc && (command_i == CMD_SAMPLE) &&
                      (8'(sample_class_i) < 8'(n_eff));
  assign acc_finish = in_acc && (command_i == CMD_FINISH);

  // Memories.
  logic [COUNT_BITS-1:0] cnt_mem [MAX_CLASSES];
  logic [LOSS_W-1:0]     loss_mem [MAX_CLASSES * MAX_CLASSES];
  logic [MAX_CLASSES-1:0] cnt_vld_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [LOSS_W-1:0]     loss_rd_q;
  logic [CLS_W-1:0]      cnt_raddr;
  logic [LA_W-1:0]       loss_waddr, loss_raddr;

  // Finish sequencer indices.
  logic [CLS_W-1:0] i_q, i_d, j_q, j_d;

  assign loss_waddr = LA_W'(int'(CLS_W'(loss_row_i)) * MAX_CLASSES +
                            int'(CLS_W'(loss_col_i)));
  assign loss_raddr = LA_W'(int'(i_q) * MAX_CLASSES + int'(j_q));
  assign cnt_raddr  = (state_q == ST_IDLE) ? CLS_W'(sample_class_i) : j_q;

  // Sample increment stage with forwarding of a write to the same class.
  logic                  s1_vld_q;
  logic [CLS_W-1:0]      s1_cls_q;
  logic                  byp_q;
  logic [COUNT_BITS-1:0] byp_val_q;
  logic [COUNT_BITS-1:0] s1_cur, s1_new;

  always_comb begin
    if (byp_q) begin
      s1_cur = byp_val_q;
    end else if (cnt_vld_q[s1_cls_q]) begin
      s1_cur = cnt_rd_q;
    end else begin
      s1_cur = '0;
    end
    s1_new = (s1_cur == '1) ? s1_cur : s1_cur + COUNT_BITS'(1);
  end

  always_ff @(posedge clk_i) begin
    cnt_rd_q  <= cnt_mem[cnt_raddr];
    loss_rd_q <= loss_mem[loss_raddr];
    if (s1_vld_q) begin
      cnt_mem[s1_cls_q] <= s1_new;
    end
    if (acc_load) begin
      loss_mem[loss_waddr] <= loss_value_i;
    end
  end

  // Multiply-accumulate pipeline.
  logic                  p1_vld_q, p1_first_j_q, p1_last_j_q, p1_first_i_q, p1_last_q;
  logic [CLS_W-1:0]      p1_j_q;
  logic                  p2_vld_q, p2_first_j_q, p2_last_j_q, p2_first_i_q, p2_last_q;
  logic [PROD_W-1:0]     p2_prod_q, p2_prod_d;
  logic                  p3_row_q, p3_first_i_q, p3_last_q;
  logic [SUM_W-1:0]      acc_q, acc_d;
  logic [SUM_W-1:0]      best_q;
  logic                  done_q;
  logic                  emit;
  logic [SUM_W+COST_W-1:0] best_ext;
  logic [COUNT_BITS-1:0] p1_cnt;

  assign p1_cnt    = cnt_vld_q[p1_j_q] ? cnt_rd_q : '0;
  assign p2_prod_d = PROD_W'(p1_cnt) * PROD_W'(loss_rd_q);
  assign acc_d     = (p2_first_j_q ? '0 : acc_q) + SUM_W'(p2_prod_q);
  assign best_ext  = {{COST_W{1'b0}}, best_q};
  assign emit      = (state_q == ST_DRAIN) && done_q && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i) begin
    s1_cls_q  <= CLS_W'(sample_class_i);
    byp_val_q <= s1_new;
    p1_j_q    <= j_q;
    p2_prod_q <= p2_prod_d;
    if (p2_vld_q) begin
      acc_q <= acc_d;
    end
    if (p3_row_q && (p3_first_i_q || (acc_q < best_q))) begin
      best_q <= acc_q;
    end
    if (emit) begin
      min_cost_o <= best_ext[COST_W-1:0];
    end
  end

  // State machine.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    unique case (state_q)
      ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        if (acc_finish) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (j_q == last_idx) begin
          j_d = '0;
          if (i_q == last_idx) begin
            state_d = ST_DRAIN;
          end else begin
            i_d = i_q + CLS_W'(1);
          end
        end else begin
          j_d = j_q + CLS_W'(1);
        end
      end
      ST_DRAIN: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      s1_vld_q     <= 1'b0;
      byp_q        <= 1'b0;
      cnt_vld_q    <= '0;
      p1_vld_q     <= 1'b0;
      p1_first_j_q <= 1'b0;
      p1_last_j_q  <= 1'b0;
      p1_first_i_q <= 1'b0;
      p1_last_q    <= 1'b0;
      p2_vld_q     <= 1'b0;
      p2_first_j_q <= 1'b0;
      p2_last_j_q  <= 1'b0;
      p2_first_i_q <= 1'b0;
      p2_last_q    <= 1'b0;
      p3_row_q     <= 1'b0;
      p3_first_i_q <= 1'b0;
      p3_last_q    <= 1'b0;
      done_q       <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      s1_vld_q <= acc_sample;
      byp_q    <= acc_sample && s1_vld_q && (CLS_W'(sample_class_i) == s1_cls_q);
      if (emit) begin
        cnt_vld_q <= '0;
      end else if (s1_vld_q) begin
        cnt_vld_q[s1_cls_q] <= 1'b1;
      end
      p1_vld_q     <= (state_q == ST_RUN);
      p1_first_j_q <= (j_q == '0);
      p1_last_j_q  <= (j_q == last_idx);
      p1_first_i_q <= (i_q == '0);
      p1_last_q    <= (i_q == last_idx) && (j_q == last_idx);
      p2_vld_q     <= p1_vld_q;
      p2_first_j_q <= p1_first_j_q;
      p2_last_j_q  <= p1_vld_q && p1_last_j_q;
      p2_first_i_q <= p1_first_i_q;
      p2_last_q    <= p1_vld_q && p1_last_q;
      p3_row_q     <= p2_vld_q && p2_last_j_q;
      p3_first_i_q <= p2_first_i_q;
      p3_last_q    <= p2_vld_q && p2_last_q;
      if (emit) begin
        done_q <= 1'b0;
      end else if (p3_last_q) begin
        done_q <= 1'b1;
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmc_checker.sv =====
// Port checker of the misclassification cost block and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module mmc_checker
  import mmc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [CMD_W-1:0]   command_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [COST_W-1:0]  min_cost_o
);

  `MMC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_cost_o), "Result item changed or vanished while stalled.")
  `MMC_ASSERT_ALWAYS(a_out_reset, !rst_ni && $past(!rst_ni) |-> !out_valid_o, "Result item shown during reset.")
  `MMC_ASSERT(a_finish_busy, in_valid_i && in_ready_o && (command_i == CMD_FINISH) |=> !in_ready_o, "Input item accepted while a finish is being worked out.")
  `MMC_ASSERT(a_out_from_finish, $rose(out_valid_o) |-> $past(!in_ready_o), "Result item appeared without a finish in progress.")

endmodule

bind min_misclassification_cost mmc_checker u_mmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .min_cost_o  (min_cost_o)
);

`default_nettype wire

// ===== dv/min_misclassification_cost_tb.sv =====
// Self-checking misclassification cost testbench: directed table, random phases, largest-cost run.
`default_nettype none

module min_misclassification_cost_tb
  import mmc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CLS       = 8;
  localparam int CNT_BITS      = 16;
  localparam int N_PHASES      = 9;
  localparam int PHASE_ITEMS   = 90;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [CNT_BITS-1:0] CNT_MAX    = '1;
  localparam logic [CMD_W-1:0]    CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [CLS_FLD_W-1:0] cls;
    logic [CLS_FLD_W-1:0] row;
    logic [CLS_FLD_W-1:0] col;
    logic [LOSS_W-1:0]    val;
    logic                 typed;
    logic [COST_W-1:0]    cost;
  } dir_item_t;

  localparam dir_item_t DIR_TBL [20] = '{
    '{CMD_LOAD,   3'd0, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_LOAD,   3'd0, 3'd0, 3'd1, 16'hFFFF, 1'b0, 35'd0},
    '{CMD_LOAD,   3'd0, 3'd1, 3'd0, 16'h0001, 1'b0, 35'd0},
    '{CMD_LOAD,   3'd0, 3'd1, 3'd1, 16'h0000, 1'b0, 35'd0},
    '{CMD_LOAD,   3'd7, 3'd7, 3'd7, 16'hA5A5, 1'b0, 35'd0},
    '{CMD_FINISH, 3'd0, 3'd0, 3'd0, 16'h0000, 1'b1, 35'd0},
    '{CMD_SAMPLE, 3'd0, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_SAMPLE, 3'd1, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_SAMPLE, 3'd1, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_SAMPLE, 3'd7, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_SAMPLE, 3'd2, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_UNUSED, 3'd7, 3'd7, 3'd7, 16'hFFFF, 1'b0, 35'd0},
    '{CMD_FINISH, 3'd0, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_SAMPLE, 3'd1, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_FINISH, 3'd0, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_FINISH, 3'd0, 3'd0, 3'd0, 16'h0000, 1'b1, 35'd0},
    '{CMD_LOAD,   3'd0, 3'd1, 3'd1, 16'hFFFF, 1'b0, 35'd0},
    '{CMD_SAMPLE, 3'd0, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_SAMPLE, 3'd1, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
    '{CMD_FINISH, 3'd0, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0}
  };

  localparam logic [NCLS_W-1:0] NCLS_SET [N_PHASES] = '{
    4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd3, 4'd10, 4'd4, 4'd2
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     command_i;
  logic [CLS_FLD_W-1:0] sample_class_i;
  logic [CLS_FLD_W-1:0] loss_row_i;
  logic [CLS_FLD_W-1:0] loss_col_i;
  logic [LOSS_W-1:0]    loss_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [COST_W-1:0]    min_cost_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  logic [LOSS_W-1:0]   loss_m [MAX_CLS][MAX_CLS];
  logic [CNT_BITS-1:0] count_m [MAX_CLS];
  logic [NCLS_W-1:0]   ncls_m;
  logic [COST_W-1:0]   cost_q [$];
  int                  mism_cnt;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  int                  hold_left;
  bit                  hold_go;

  min_misclassification_cost #(
    .MAX_CLASSES(MAX_CLS),
    .COUNT_BITS (CNT_BITS)
  ) dut (.*);

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int active_classes();
    if (ncls_m == '0) begin
      return 1;
    end
    if (int'(ncls_m) > MAX_CLS) begin
      return MAX_CLS;
    end
    return int'(ncls_m);
  endfunction

  task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [CLS_FLD_W-1:0] cls,
                            input logic [CLS_FLD_W-1:0] row, input logic [CLS_FLD_W-1:0] col,
                            input logic [LOSS_W-1:0] val, output bit emits,
                            output logic [COST_W-1:0] cost);
    int n;
    int i;
    int j;
    logic [63:0] sum;
    logic [63:0] best;
    n = active_classes();
    emits = 1'b0;
    cost = '0;
    case (cmd)
      CMD_LOAD: begin
        loss_m[row][col] = val;
      end
      CMD_SAMPLE: begin
        if (int'(cls) < n && count_m[cls] != CNT_MAX) count_m[cls] += 1'b1;
      end
      CMD_FINISH: begin
        best = '0;
        for (i = 0; i < n; i++) begin
          sum = '0;
          for (j = 0; j < n; j++) sum += 64'(count_m[j]) * 64'(loss_m[i][j]);
          if (i == 0 || sum < best) best = sum;
        end
        for (i = 0; i < MAX_CLS; i++) count_m[i] = '0;
        emits = 1'b1;
        cost = best[COST_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CLS_FLD_W-1:0] cls,
                           input logic [CLS_FLD_W-1:0] row, input logic [CLS_FLD_W-1:0] col,
                           input logic [LOSS_W-1:0] val, input logic typed = 1'b0,
                           input logic [COST_W-1:0] typed_cost = '0);
    bit emits;
    logic [COST_W-1:0] cost;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    sample_class_i <= cls;
    loss_row_i     <= row;
    loss_col_i     <= col;
    loss_value_i   <= val;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(cmd, cls, row, col, val, emits, cost);
    if (emits) cost_q = {cost_q, (typed ? typed_cost : cost)};
    @(negedge clk_i);
  endtask

  task automatic random_item(output bit counted);
    int n;
    int r;
    logic [CMD_W-1:0] cmd;
    logic [CLS_FLD_W-1:0] cls;
    n = active_classes();
    r = $urandom_range(99);
    cls = CLS_FLD_W'($urandom_range(MAX_CLS - 1));
    if (r < 7) begin
      cmd = CMD_FINISH;
    end else if (r < 20) begin
      cmd = CMD_LOAD;
    end else if (r < 25) begin
      cmd = CMD_UNUSED;
    end else begin
      cmd = CMD_SAMPLE;
      if (r < 92) cls = CLS_FLD_W'($urandom_range(n - 1));
    end
    counted = (cmd != CMD_UNUSED) && !(cmd == CMD_SAMPLE && int'(cls) >= n);
    send_item(cmd, cls, CLS_FLD_W'($urandom_range(MAX_CLS - 1)),
              CLS_FLD_W'($urandom_range(MAX_CLS - 1)), LOSS_W'($urandom_range(16'hFFFF)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (cost_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_ncls(input logic [NCLS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * REG_NUM_CLASSES);
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ncls_m = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [COST_W-1:0] want,
                               input logic [COST_W-1:0] got);
    mism_cnt++;
    if (mism_cnt <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cost_q.size() == 0) begin
        note_mismatch("min_cost with no finish pending", '0, min_cost_o);
      end else if (min_cost_o !== cost_q[0]) begin
        note_mismatch("min_cost", cost_q.pop_front(), min_cost_o);
      end else begin
        void'(cost_q.pop_front());
      end
    end
  end

  initial begin
    int done;
    int p;
    int r;
    int c;
    int k;
    bit counted;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_LOAD;
    sample_class_i = '0;
    loss_row_i     = '0;
    loss_col_i     = '0;
    loss_value_i   = '0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hold_go        = 1'b0;
    hold_left      = 0;
    mism_cnt       = 0;
    tx_idle_pct    = 7;
    rx_idle_pct    = 54;
    ncls_m         = NCLS_RESET;
    for (r = 0; r < MAX_CLS; r++) begin
      count_m[r] = '0;
      for (c = 0; c < MAX_CLS; c++) loss_m[r][c] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIR_TBL[k]) begin
      send_item(DIR_TBL[k].cmd, DIR_TBL[k].cls, DIR_TBL[k].row, DIR_TBL[k].col,
                DIR_TBL[k].val, DIR_TBL[k].typed, DIR_TBL[k].cost);
    end
    drain();

    for (p = 0; p < N_PHASES; p++) begin
      tx_idle_pct = (p < 3) ? 7 : (p < 6) ? 54 : 0;
      rx_idle_pct = (p < 3) ? 54 : (p < 6) ? 7 : 0;
      write_ncls(NCLS_SET[p]);
      if (p == 0) begin
        // Every finish from here on may read any entry, so the whole table is loaded first.
        for (r = 0; r < MAX_CLS; r++) begin
          for (c = 0; c < MAX_CLS; c++) begin
            send_item(CMD_LOAD, CLS_FLD_W'($urandom_range(MAX_CLS - 1)), CLS_FLD_W'(r),
                      CLS_FLD_W'(c), LOSS_W'($urandom_range(16'hFFFF)));
          end
        end
      end
      if (p == 3) begin
        hold_go = 1'b1;
        for (k = 0; k < 4; k++) begin
          send_item(CMD_SAMPLE, CLS_FLD_W'(k), 3'd0, 3'd0, 16'h0000);
          send_item(CMD_FINISH, 3'd0, 3'd0, 3'd0, 16'h0000);
        end
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) done++;
      end
      drain();
    end

    // Several counts in every class against the heaviest table give the largest cost of the run.
    write_ncls(NCLS_W'(MAX_CLS));
    for (r = 0; r < MAX_CLS; r++) begin
      for (c = 0; c < MAX_CLS; c++) begin
        send_item(CMD_LOAD, 3'd0, CLS_FLD_W'(r), CLS_FLD_W'(c), 16'hFFFF);
      end
    end
    for (k = 0; k < MAX_CLS * 4; k++) begin
      send_item(CMD_SAMPLE, CLS_FLD_W'(k % MAX_CLS), 3'd0, 3'd0, 16'h0000);
    end
    send_item(CMD_FINISH, 3'd0, 3'd0, 3'd0, 16'h0000);
    drain();

    if (mism_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
